>>> hw/rtl/cbd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbd_pkg
// Shared widths, types, constant tables and coefficients of the 2x2 block
// decoder.
// ---------------------------------------------------------------------------
package cbd_pkg;

    // configuration port
    localparam int ADDR_W     = 5;     // four 64-bit registers at 8*i
    localparam int DATA_W     = 64;
    localparam int REG_LSB    = 3;     // byte offset bits inside one register
    localparam int NUM_REGS   = 4;

    // arithmetic widths
    localparam int Q16_W      = 17;    // Q16 coefficients and chroma
    localparam int Y_W        = 19;    // luma sample, Q16
    localparam int TERM_W     = 35;    // coefficient times chroma, Q32
    localparam int SUM_W      = 38;    // channel sum, Q32
    localparam int V_W        = 46;    // channel sum times 255
    localparam int CH_W       = 8;

    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam int QCNT_W     = 3;

    localparam int PIX_W      = 2;
    localparam logic [PIX_W-1:0] PIX_LAST = 2'd3;

    // YPbPr to RGB matrix in Q16
    localparam logic signed [17:0] COEF_R_PR = 18'sd91881;
    localparam logic signed [17:0] COEF_G_PB = 18'sd22553;
    localparam logic signed [17:0] COEF_G_PR = 18'sd46802;
    localparam logic signed [17:0] COEF_B_PB = 18'sd116130;

    typedef logic signed [Q16_W-1:0] t_q16;
    typedef t_q16 t_q16_tab [64];

    // 16 chroma entries, Q1.15; entry 4w+k sits in bits 16k+15..16k of word w
    typedef logic [15:0][15:0]       t_chroma_tab;
    typedef logic [NUM_REGS-1:0][DATA_W-1:0] t_chroma_regs;

    // one decoded block, as it waits in the queue
    typedef struct packed {
        logic [3:0][Y_W-1:0]        y;    // luma in output order
        logic signed [TERM_W-1:0]   cr;   // 1.402 * Pr
        logic signed [TERM_W-1:0]   cgb;  // 0.344136 * Pb
        logic signed [TERM_W-1:0]   cgr;  // 0.714136 * Pr
        logic signed [TERM_W-1:0]   cb;   // 1.772 * Pb
    } t_item;

    typedef struct packed {
        logic f1_valid;
        logic f2_valid;
    } t_front_status;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    // a / 511 in Q16, rounded
    function automatic t_q16_tab build_qa_tab();
        t_q16_tab tab;
        for (int i = 0; i < 64; i++) begin
            tab[i] = Q16_W'((i * 65536 + 255) / 511);
        end
        return tab;
    endfunction

    // signed 6-bit code / 50 in Q16, rounded half away from zero
    function automatic t_q16_tab build_ac_tab();
        t_q16_tab tab;
        int m;
        int v;
        for (int i = 0; i < 64; i++) begin
            m = (i >= 32) ? 64 - i : i;
            v = (m * 65536 + 25) / 50;
            tab[i] = (i >= 32) ? Q16_W'(-v) : Q16_W'(v);
        end
        return tab;
    endfunction

    localparam t_q16_tab QA_TAB = build_qa_tab();
    localparam t_q16_tab AC_TAB = build_ac_tab();

endpackage

>>> hw/rtl/cbd_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbd_front
// Accepts a codeword, looks up the DC/AC and chroma values, forms the four
// luma samples and the chroma products, and pushes one queue entry.
// ---------------------------------------------------------------------------
module cbd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [31:0]            i_code_word,
    input  cbd_pkg::t_chroma_tab   i_chroma,
    output cbd_pkg::t_front_status o_status,
    output logic                   o_push,
    output cbd_pkg::t_item         o_item
);

    // stage 1: table lookups
    logic                r_f1_valid;
    cbd_pkg::t_q16       r_qa, r_qb, r_qc, r_qd, r_pb, r_pr;
    // stage 2: luma butterfly and chroma products
    logic                r_f2_valid;
    cbd_pkg::t_item      r_item;

    logic [15:0]         pb_raw, pr_raw;
    logic signed [cbd_pkg::Y_W-1:0]    y00, y01, y10, y11;
    logic signed [cbd_pkg::TERM_W-1:0] prod_r, prod_gb, prod_gr, prod_b;

    assign pb_raw = i_chroma[i_code_word[7:4]];
    assign pr_raw = i_chroma[i_code_word[3:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            r_f1_valid <= i_accept;
            r_f2_valid <= r_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_qa <= cbd_pkg::QA_TAB[i_code_word[31:26]];
            r_qb <= cbd_pkg::AC_TAB[i_code_word[25:20]];
            r_qc <= cbd_pkg::AC_TAB[i_code_word[19:14]];
            r_qd <= cbd_pkg::AC_TAB[i_code_word[13:8]];
            // Q15 to Q16 by doubling
            r_pb <= $signed({pb_raw, 1'b0});
            r_pr <= $signed({pr_raw, 1'b0});
        end
    end

    assign y00 = cbd_pkg::Y_W'(r_qa) - cbd_pkg::Y_W'(r_qb) - cbd_pkg::Y_W'(r_qc)
               + cbd_pkg::Y_W'(r_qd);
    assign y01 = cbd_pkg::Y_W'(r_qa) - cbd_pkg::Y_W'(r_qb) + cbd_pkg::Y_W'(r_qc)
               - cbd_pkg::Y_W'(r_qd);
    assign y10 = cbd_pkg::Y_W'(r_qa) + cbd_pkg::Y_W'(r_qb) - cbd_pkg::Y_W'(r_qc)
               - cbd_pkg::Y_W'(r_qd);
    assign y11 = cbd_pkg::Y_W'(r_qa) + cbd_pkg::Y_W'(r_qb) + cbd_pkg::Y_W'(r_qc)
               + cbd_pkg::Y_W'(r_qd);

    assign prod_r  = cbd_pkg::COEF_R_PR * r_pr;
    assign prod_gb = cbd_pkg::COEF_G_PB * r_pb;
    assign prod_gr = cbd_pkg::COEF_G_PR * r_pr;
    assign prod_b  = cbd_pkg::COEF_B_PB * r_pb;

    always_ff @(posedge i_clk) begin
        if (r_f1_valid) begin
            r_item.y   <= {y11, y10, y01, y00};
            r_item.cr  <= prod_r;
            r_item.cgb <= prod_gb;
            r_item.cgr <= prod_gr;
            r_item.cb  <= prod_b;
        end
    end

    assign o_status.f1_valid = r_f1_valid;
    assign o_status.f2_valid = r_f2_valid;
    assign o_push            = r_f2_valid;
    assign o_item            = r_item;

endmodule

>>> hw/rtl/cbd_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbd_queue
// Short FIFO of decoded blocks between front and back.
// ---------------------------------------------------------------------------
module cbd_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  cbd_pkg::t_item              i_item,
    input  logic                        i_pop,
    output cbd_pkg::t_queue_head        o_head,
    output logic [cbd_pkg::QCNT_W-1:0]  o_count
);

    cbd_pkg::t_item                r_mem [cbd_pkg::QDEPTH];
    logic [cbd_pkg::QPTR_W-1:0]    r_wptr, r_rptr;
    logic [cbd_pkg::QCNT_W-1:0]    r_cnt;
    logic                          pop_ok;

    assign pop_ok = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop_ok) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + cbd_pkg::QCNT_W'(i_push) - cbd_pkg::QCNT_W'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rptr];
    assign o_count      = r_cnt;

endmodule

>>> hw/rtl/cbd_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbd_back
// Drains the queue head one pixel a cycle: channel sums, scale by 255,
// round and clamp, registered result strobe.
// ---------------------------------------------------------------------------
module cbd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cbd_pkg::t_queue_head      i_head,
    output logic                      o_pop,
    output logic                      o_strobe,
    output logic [cbd_pkg::CH_W-1:0]  o_red,
    output logic [cbd_pkg::CH_W-1:0]  o_green,
    output logic [cbd_pkg::CH_W-1:0]  o_blue,
    output logic                      o_column_offset,
    output logic                      o_row_offset,
    output logic                      o_last_pixel
);

    localparam int QW = cbd_pkg::V_W - 32;

    // rounds a Q32 value half up (positive only) and clamps to 0..255
    function automatic logic [cbd_pkg::CH_W-1:0] to_channel(
        input logic signed [cbd_pkg::V_W-1:0] v
    );
        logic [cbd_pkg::V_W-1:0] rnd;
        logic [QW-1:0]           q;
        rnd = cbd_pkg::V_W'(v) + (cbd_pkg::V_W'(1) << 31);
        q   = rnd[cbd_pkg::V_W-1:32];
        if (v[cbd_pkg::V_W-1] || (v == '0)) begin
            return '0;
        end else if (|q[QW-1:cbd_pkg::CH_W]) begin
            return '1;
        end
        return q[cbd_pkg::CH_W-1:0];
    endfunction

    logic [cbd_pkg::PIX_W-1:0]          r_pix;
    logic signed [cbd_pkg::Y_W-1:0]     ysel;
    logic signed [cbd_pkg::TERM_W-1:0]  yq;
    logic signed [cbd_pkg::SUM_W-1:0]   sum_r, sum_g, sum_b;

    // stage 1: sums
    logic                               r_b1_valid;
    logic signed [cbd_pkg::SUM_W-1:0]   r_sr, r_sg, r_sb;
    logic [cbd_pkg::PIX_W-1:0]          r_b1_pix;
    // stage 2: times 255
    logic                               r_b2_valid;
    logic signed [cbd_pkg::V_W-1:0]     r_vr, r_vg, r_vb;
    logic [cbd_pkg::PIX_W-1:0]          r_b2_pix;
    logic signed [cbd_pkg::V_W-1:0]     xr, xg, xb;

    assign o_pop = i_head.valid && (r_pix == cbd_pkg::PIX_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix <= '0;
        end else if (i_head.valid) begin
            r_pix <= r_pix + 1'b1;
        end
    end

    assign ysel  = $signed(i_head.item.y[r_pix]);
    assign yq    = $signed({ysel, 16'd0});
    assign sum_r = cbd_pkg::SUM_W'(yq) + cbd_pkg::SUM_W'(i_head.item.cr);
    assign sum_g = cbd_pkg::SUM_W'(yq) - cbd_pkg::SUM_W'(i_head.item.cgb)
                 - cbd_pkg::SUM_W'(i_head.item.cgr);
    assign sum_b = cbd_pkg::SUM_W'(yq) + cbd_pkg::SUM_W'(i_head.item.cb);

    assign xr = cbd_pkg::V_W'(r_sr);
    assign xg = cbd_pkg::V_W'(r_sg);
    assign xb = cbd_pkg::V_W'(r_sb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            o_strobe   <= 1'b0;
        end else begin
            r_b1_valid <= i_head.valid;
            r_b2_valid <= r_b1_valid;
            o_strobe   <= r_b2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sr     <= sum_r;
        r_sg     <= sum_g;
        r_sb     <= sum_b;
        r_b1_pix <= r_pix;
        r_vr     <= (xr <<< 8) - xr;
        r_vg     <= (xg <<< 8) - xg;
        r_vb     <= (xb <<< 8) - xb;
        r_b2_pix <= r_b1_pix;
        o_red           <= to_channel(r_vr);
        o_green         <= to_channel(r_vg);
        o_blue          <= to_channel(r_vb);
        o_column_offset <= r_b2_pix[1];
        o_row_offset    <= r_b2_pix[0];
        o_last_pixel    <= (r_b2_pix == cbd_pkg::PIX_LAST);
    end

endmodule

>>> hw/rtl/codeword_to_rgb_block_decoder_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// codeword_to_rgb_block_decoder_unit
// Decodes one 32-bit codeword (DC/AC luma terms plus two chroma indices)
// into the four RGB pixels of a 2x2 block.
// ---------------------------------------------------------------------------
//
//  channel   | signals                                   | transaction
//  ----------+-------------------------------------------+--------------------
//  command   | start, busy, i_code_word                  | start && !busy
//  pixel out | o_strobe, o_red/green/blue, o_*_offset,   | every o_strobe cycle
//            | o_last_pixel                              |
//  config    | psel, penable, pwrite, paddr, pwdata,     | psel && penable &&
//            | prdata, pready                            | pwrite (pready = 1)
//
//  Four pixels per codeword, one per cycle, ordered (col0,row0), (col0,row1),
//  (col1,row0), (col1,row1); the back end's one-pixel-per-cycle drain sets
//  the sustained codeword rate.
//  Path from an accepted codeword to the o_strobe of its first pixel: 2 front
//  stages, queue write, 3 back stages.
//  busy rises when the 4-entry queue plus the front stages in flight would
//  overflow; codewords may arrive back to back until then.
//  Synchronous active-low reset clears the chroma table to zero and empties
//  the pipeline. The pixel receiver cannot stall.
// ---------------------------------------------------------------------------
module codeword_to_rgb_block_decoder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command
    input  logic                         start,
    output logic                         busy,
    input  logic [31:0]                  i_code_word,
    // pixel results
    output logic                         o_strobe,
    output logic [cbd_pkg::CH_W-1:0]     o_red,
    output logic [cbd_pkg::CH_W-1:0]     o_green,
    output logic [cbd_pkg::CH_W-1:0]     o_blue,
    output logic                         o_column_offset,
    output logic                         o_row_offset,
    output logic                         o_last_pixel,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cbd_pkg::ADDR_W-1:0]   paddr,
    input  logic [cbd_pkg::DATA_W-1:0]   pwdata,
    output logic [cbd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    // Chroma table: register w holds entries 4w..4w+3
    cbd_pkg::t_chroma_regs          r_chroma;
    cbd_pkg::t_chroma_tab           chroma_tab;
    logic [cbd_pkg::ADDR_W-cbd_pkg::REG_LSB-1:0] reg_idx;

    logic                           accept;
    cbd_pkg::t_front_status         front_status;
    logic                           push;
    cbd_pkg::t_item                 push_item;
    logic                           pop;
    cbd_pkg::t_queue_head           head;
    logic [cbd_pkg::QCNT_W-1:0]     q_count;
    logic [cbd_pkg::QCNT_W-1:0]     in_flight;

    // ---- APB register file ----
    assign reg_idx = paddr[cbd_pkg::ADDR_W-1:cbd_pkg::REG_LSB];
    assign pready  = 1'b1;
    assign prdata  = r_chroma[reg_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chroma <= '0;
        end else if (psel && penable && pwrite && pready) begin
            r_chroma[reg_idx] <= pwdata;
        end
    end

    // same bits, viewed as 16 entries of 16 bits
    assign chroma_tab = r_chroma;

    // ---- flow control ----
    // Count every block that will land in the queue, including those still
    // in the two front stages, so a push never finds the queue full.
    assign in_flight = q_count
                     + cbd_pkg::QCNT_W'(front_status.f1_valid)
                     + cbd_pkg::QCNT_W'(front_status.f2_valid);
    assign busy      = (in_flight >= cbd_pkg::QCNT_W'(cbd_pkg::QDEPTH));
    assign accept    = start && !busy;

    cbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_code_word (i_code_word),
        .i_chroma    (chroma_tab),
        .o_status    (front_status),
        .o_push      (push),
        .o_item      (push_item)
    );

    cbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    cbd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .o_strobe        (o_strobe),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_column_offset (o_column_offset),
        .o_row_offset    (o_row_offset),
        .o_last_pixel    (o_last_pixel)
    );

endmodule

>>> hw/rtl/cbd_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbd_checker
// Port-level checks on the pixel burst of the block decoder.
// ---------------------------------------------------------------------------
module cbd_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic o_strobe,
    input  logic o_column_offset,
    input  logic o_row_offset,
    input  logic o_last_pixel,
    input  logic pready
);

    // a block's four pixels come without gaps
    a_burst_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_pixel |=> o_strobe)
        else $error("pixel burst broken");

    // pixel position steps by one inside a burst
    a_pixel_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_pixel |=>
            ({o_column_offset, o_row_offset}
             == 2'($past({o_column_offset, o_row_offset}) + 2'd1)))
        else $error("pixel order wrong");

    // last flag marks the bottom-right pixel only
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last_pixel == (o_column_offset && o_row_offset)))
        else $error("last flag mismatch");

    // a pixel right after a last one starts a new block
    a_new_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last_pixel ##1 o_strobe |-> !o_column_offset && !o_row_offset)
        else $error("block does not start top-left");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind codeword_to_rgb_block_decoder_unit cbd_checker u_cbd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_strobe        (o_strobe),
    .o_column_offset (o_column_offset),
    .o_row_offset    (o_row_offset),
    .o_last_pixel    (o_last_pixel),
    .pready          (pready)
);
